@@ rtl/assert_macros.svh @@
// Assertion macros used by the planner back end.
// Holds concurrent assertion helpers with a clock and an active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assert a property on every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("lbl");

// assert an implication on every clock edge outside reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error("lbl");

`endif

@@ rtl/srp_pkg.sv @@
// Types and constants for the stepper ramp planner.
// No dependencies.
`timescale 1ns / 1ps
package srp_pkg;
    localparam logic [2:0] ST_STARTED   = 3'd0;
    localparam logic [2:0] ST_BUSY      = 3'd1;
    localparam logic [2:0] ST_ZERO_STEP = 3'd2;
    localparam logic [2:0] ST_ZERO_PAR  = 3'd3;
    localparam logic [2:0] ST_DONE      = 3'd4;

    localparam logic [1:0] RAMP_ACCEL = 2'd0;
    localparam logic [1:0] RAMP_RUN   = 2'd1;
    localparam logic [1:0] RAMP_DECEL = 2'd2;

    localparam logic [1:0] CFG_SPEED_SCALE    = 2'd0;
    localparam logic [1:0] CFG_FIRST_DELAY_SQ = 2'd1;
    localparam logic [1:0] CFG_ALPHA_X200     = 2'd2;

    localparam logic [31:0] SINGLE_STEP_DELAY = 32'd1000;

    // classified move handed from front to back
    typedef struct packed {
        logic [2:0]  status;
        logic        full;      // needs the ramp arithmetic
        logic        dir;
        logic [32:0] step;      // magnitude, up to 2^31
        logic [15:0] accel;
        logic [15:0] decel;
        logic [15:0] speed;
        logic [15:0] cur;
    } t_job;

    typedef struct packed {
        logic [2:0]  status;
        logic        dir;
        logic [1:0]  ramp;
        logic [31:0] first;
        logic [31:0] mind;
        logic [31:0] dcount;
        logic [30:0] dstart;
        logic        acinit;
        logic [15:0] nextc;
    } t_res;
endpackage

@@ rtl/srp_front.sv @@
// Front end: accepts items, tracks busy motors and classifies moves.
// Depends on srp_pkg.
`timescale 1ns / 1ps
module srp_front #(
    parameter int MOTOR_COUNT = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic            i_op,
    input  logic [3:0]      i_motor,
    input  logic [31:0]     i_steps,
    input  logic [15:0]     i_accel,
    input  logic [15:0]     i_decel,
    input  logic [15:0]     i_speed,
    input  logic [15:0]     i_cur,
    output logic            o_valid,
    input  logic            i_ready,
    output srp_pkg::t_job   o_job
);
    logic [MOTOR_COUNT-1:0] r_busy, n_busy;
    logic [6:0] w_m;
    logic       w_inr;
    logic       w_busy;
    logic [32:0] w_step;
    srp_pkg::t_job w_job;

    assign o_ready = !o_valid || i_ready;
    assign w_m     = {3'b000, i_motor};
    assign w_inr   = w_m < 7'(MOTOR_COUNT);
    assign w_busy  = w_inr && r_busy[i_motor];
    assign w_step  = i_steps[31] ? (33'd0 - {i_steps[31], i_steps}) : {1'b0, i_steps};

    always_comb begin
        n_busy = r_busy;
        w_job = '0;
        w_job.step  = w_step;
        w_job.accel = i_accel;
        w_job.decel = i_decel;
        w_job.speed = i_speed;
        w_job.cur   = i_cur;
        w_job.dir   = !i_steps[31];
        if (i_op) begin
            w_job.status = srp_pkg::ST_DONE;
            if (w_inr) begin
                n_busy[i_motor] = 1'b0;
            end
        end else if (!w_inr || w_busy) begin
            w_job.status = srp_pkg::ST_BUSY;
        end else if (w_step == '0) begin
            w_job.status = srp_pkg::ST_ZERO_STEP;
        end else if (i_accel == '0 || i_decel == '0 || i_speed == '0) begin
            w_job.status = srp_pkg::ST_ZERO_PAR;
        end else begin
            w_job.status = srp_pkg::ST_STARTED;
            w_job.full   = 1'b1;
            n_busy[i_motor] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= '0;
            o_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_busy  <= n_busy;
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            o_job <= w_job;
        end
    end
endmodule

@@ rtl/srp_divsqrt.sv @@
// Shared iterative unit: 64/64 restoring divide, or 64-bit integer square root.
// Depends on nothing; one bit of quotient or root per cycle.
`timescale 1ns / 1ps
module srp_divsqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_sqrt,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_q
);
    logic        r_run, r_sqrt;
    logic [6:0]  r_cnt;
    logic [63:0] r_a, r_b, r_q;
    logic [65:0] r_rem;
    logic [65:0] w_rem, w_trial;
    logic [65:0] w_sub;

    always_comb begin
        if (r_sqrt) begin
            w_rem   = {r_rem[63:0], r_a[63:62]};
            w_trial = {r_q, 2'b01};
        end else begin
            w_rem   = {r_rem[64:0], r_a[63]};
            w_trial = {2'b00, r_b};
        end
        w_sub = w_rem - w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_run  <= 1'b1;
                r_sqrt <= i_sqrt;
                r_a    <= i_a;
                r_b    <= i_b;
                r_q    <= '0;
                r_rem  <= '0;
                r_cnt  <= i_sqrt ? 7'd32 : 7'd64;
            end else if (r_run) begin
                if (!w_sub[65]) begin
                    r_rem <= w_sub;
                    r_q   <= {r_q[62:0], 1'b1};
                end else begin
                    r_rem <= w_rem;
                    r_q   <= {r_q[62:0], 1'b0};
                end
                r_a   <= r_sqrt ? {r_a[61:0], 2'b00} : {r_a[62:0], 1'b0};
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_run  <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_q = r_q;
endmodule

@@ rtl/srp_back.sv @@
// Back end: sequences the ramp arithmetic for a started move and holds the result.
// Depends on srp_pkg, srp_divsqrt and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module srp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [31:0]     i_speed_scale,
    input  logic [63:0]     i_first_delay_sq,
    input  logic [15:0]     i_alpha_x200,
    input  logic            i_valid,
    output logic            o_ready,
    input  srp_pkg::t_job   i_job,
    output logic            o_valid,
    input  logic            i_ready,
    output srp_pkg::t_res   o_res
);
    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_MIND  = 11'b00000000010,
        S_FDIV  = 11'b00000000100,
        S_FSQ   = 11'b00000001000,
        S_RDIV  = 11'b00000010000,
        S_MAXL  = 11'b00000100000,
        S_ACCL  = 11'b00001000000,
        S_DVD   = 11'b00010000000,
        S_FIN   = 11'b00100000000,
        S_OUT   = 11'b01000000000,
        S_MUL   = 11'b10000000000
    } t_state;

    t_state r_st;
    srp_pkg::t_job r_job;
    logic [31:0] r_mind, r_first;
    logic [63:0] r_t, r_maxl, r_accl;
    logic        r_go, r_sq;
    logic [63:0] r_a, r_b;
    logic        w_done;
    logic [63:0] w_q;
    logic [63:0] w_dv;
    logic [32:0] w_dv33;
    logic [63:0] w_recip;
    logic [31:0] w_div10;
    srp_pkg::t_res w_res;
    srp_pkg::t_res w_short;

    srp_divsqrt u_ds (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_go), .i_sqrt(r_sq),
        .i_a(r_a), .i_b(r_b), .o_done(w_done), .o_q(w_q)
    );

    assign o_ready = (r_st == S_IDLE) && !o_valid;

    // divide by ten through the reciprocal, exact for any 32-bit value
    assign w_recip = {32'd0, r_t[31:0]} * 64'h0000_0000_CCCC_CCCD;
    assign w_div10 = {3'd0, w_recip[63:35]};

    always_comb begin
        w_short = '0;
        w_short.status = i_job.status;
        if (i_job.full) begin
            w_short.dir    = i_job.dir;
            w_short.ramp   = srp_pkg::RAMP_DECEL;
            w_short.first  = srp_pkg::SINGLE_STEP_DELAY;
            w_short.acinit = 1'b1;
            w_short.nextc  = i_job.cur + srp_pkg::SINGLE_STEP_DELAY[16:1];
        end
    end

    always_comb begin
        if (r_accl <= r_maxl) w_dv = {31'd0, r_job.step} - r_accl;
        else                  w_dv = r_t;
        if (w_dv == '0) w_dv = 64'd1;
        w_dv33 = w_dv[32:0];
        w_res = '0;
        w_res.status = r_job.status;
        w_res.dir    = r_job.dir;
        w_res.mind   = r_mind;
        w_res.dcount = 32'd0 - w_dv33[31:0];
        w_res.dstart = 31'(r_job.step - w_dv33);
        if (r_first <= r_mind) begin
            w_res.first = r_mind;
            w_res.ramp  = srp_pkg::RAMP_RUN;
        end else begin
            w_res.first = r_first;
            w_res.ramp  = srp_pkg::RAMP_ACCEL;
        end
        w_res.nextc = r_job.cur + w_res.first[16:1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            o_valid <= 1'b0;
            r_go    <= 1'b0;
        end else begin
            r_go <= 1'b0;
            if (o_valid && i_ready) o_valid <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_job <= i_job;
                        if (!i_job.full || i_job.step == 33'd1) begin
                            o_res   <= w_short;
                            o_valid <= 1'b1;
                        end else begin
                            r_go <= 1'b1; r_sq <= 1'b0;
                            r_a <= {32'd0, i_speed_scale};
                            r_b <= {48'd0, i_job.speed};
                            r_st <= S_MIND;
                        end
                    end
                end
                S_MIND: if (w_done) begin
                    r_mind <= w_q[31:0];
                    r_go <= 1'b1; r_sq <= 1'b0;
                    r_a <= i_first_delay_sq; r_b <= {48'd0, r_job.accel};
                    r_st <= S_FDIV;
                end
                S_FDIV: if (w_done) begin
                    r_go <= 1'b1; r_sq <= 1'b1; r_a <= w_q;
                    r_st <= S_FSQ;
                end
                S_FSQ: if (w_done) begin
                    r_first <= w_q[31:0];
                    r_t <= {32'd0, 32'(i_alpha_x200) * 32'(r_job.accel)};
                    r_st <= S_RDIV;
                end
                S_RDIV: begin
                    r_go <= 1'b1; r_sq <= 1'b0;
                    r_a <= {32'd0, 32'(r_job.speed) * 32'(r_job.speed)};
                    r_b <= (w_div10 == '0) ? 64'd1 : {32'd0, w_div10};
                    r_st <= S_MAXL;
                end
                S_MAXL: if (w_done) begin
                    r_maxl <= (w_q == '0) ? 64'd1 : w_q;
                    r_t <= {31'd0, r_job.step} * {48'd0, r_job.decel};
                    r_st <= S_MUL;
                end
                S_MUL: begin
                    r_go <= 1'b1; r_sq <= 1'b0;
                    r_a <= r_t;
                    r_b <= {47'd0, 17'({1'b0, r_job.accel} + {1'b0, r_job.decel})};
                    r_st <= S_ACCL;
                end
                S_ACCL: if (w_done) begin
                    r_accl <= (w_q == '0) ? 64'd1 : w_q;
                    r_go <= 1'b1; r_sq <= 1'b0;
                    r_a <= {32'd0, r_maxl[31:0]} * {48'd0, r_job.accel};
                    r_b <= {48'd0, r_job.decel};
                    r_st <= S_DVD;
                end
                S_DVD: if (w_done) begin
                    r_t  <= w_q;
                    r_st <= S_FIN;
                end
                S_FIN: begin
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    o_res   <= w_res;
                    o_valid <= 1'b1;
                    r_st    <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    `ASSERT_IMP(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    `ASSERT_IMP(a_busy_state, i_clk, i_rst_n, r_st != S_IDLE, !o_ready)
    `ASSERT_IMP(a_start_idle, i_clk, i_rst_n, r_go, r_st != S_IDLE)
endmodule

@@ rtl/srp_queue.sv @@
// Two-entry job queue between front and back.
// Depends on srp_pkg.
`timescale 1ns / 1ps
module srp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  srp_pkg::t_job i_job,
    output logic          o_valid,
    input  logic          i_ready,
    output srp_pkg::t_job o_job
);
    srp_pkg::t_job r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_valid && o_ready) r_wp <= !r_wp;
            if (o_valid && i_ready) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_valid && o_ready) - 2'(o_valid && i_ready);
        end
    end
endmodule

@@ rtl/stepper_ramp_planner_core.sv @@
// An input beat is registered in the front end, then in the two-entry queue. A rejected,
// done or single-step item is registered straight into the output; a full move first runs
// the shared bit-serial divide/square-root unit (five 64-bit divides, one 32-step root).
// The back end takes a new job only when idle and its last result has been taken.
// Reset: synchronous active-low i_rst_n clears busy flags, queue and registers
// (alpha_x200 to 1); no clearing pass.
`timescale 1ns / 1ps
module stepper_ramp_planner_core #(
    parameter int MOTOR_COUNT = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,  // motor, steps, accel, decel, speed, current_compare
    input  logic         s_axis_tuser,  // operation
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [151:0] m_axis_tdata,  // status, direction, ramp_state, first_delay,
                                        // top-speed delay, decel_count, slow-down step,
                                        // accel_count_init, next_compare
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data
);
    logic [31:0] r_mds;
    logic [63:0] r_fds;
    logic [15:0] r_alpha;
    logic f_v, f_r, q_v, q_r;
    srp_pkg::t_job f_job, q_job;
    srp_pkg::t_res w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mds <= '0; r_fds <= '0; r_alpha <= 16'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                srp_pkg::CFG_SPEED_SCALE:    r_mds   <= i_cfg_data[31:0];
                srp_pkg::CFG_FIRST_DELAY_SQ: r_fds   <= i_cfg_data;
                srp_pkg::CFG_ALPHA_X200:     r_alpha <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    srp_front #(.MOTOR_COUNT(MOTOR_COUNT)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_op(s_axis_tuser), .i_motor(s_axis_tdata[3:0]), .i_steps(s_axis_tdata[35:4]),
        .i_accel(s_axis_tdata[51:36]), .i_decel(s_axis_tdata[67:52]),
        .i_speed(s_axis_tdata[83:68]), .i_cur(s_axis_tdata[99:84]),
        .o_valid(f_v), .i_ready(f_r), .o_job(f_job)
    );

    srp_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_v), .o_ready(f_r), .i_job(f_job),
        .o_valid(q_v), .i_ready(q_r), .o_job(q_job)
    );

    srp_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_speed_scale(r_mds), .i_first_delay_sq(r_fds), .i_alpha_x200(r_alpha),
        .i_valid(q_v), .o_ready(q_r), .i_job(q_job),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(w_res)
    );

    assign m_axis_tdata = {2'd0, w_res.nextc, w_res.acinit, w_res.dstart, w_res.dcount,
                           w_res.mind, w_res.first, w_res.ramp, w_res.dir, w_res.status};
endmodule

@@ tb/sv/stepper_ramp_planner_core_tb.sv @@
// Testbench for stepper_ramp_planner_core: drives move requests and done events on
// the input stream, predicts each planned move and compares every output beat.
// Depends on srp_pkg and the core RTL.
`timescale 1ns / 1ps
module stepper_ramp_planner_core_tb;

    localparam int MOTORS = 16;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [15:0] nextc;
        logic        acinit;
        logic [30:0] dstart;
        logic [31:0] dcount;
        logic [31:0] mind;
        logic [31:0] first;
        logic [1:0]  ramp;
        logic        dir;
        logic [2:0]  status;
    } t_plan;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata;   // motor, steps, accel, decel, speed, current_compare
    logic         s_axis_tuser;   // operation
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [151:0] m_axis_tdata;   // status, direction, ramp_state, first_delay,
                                  // top-speed delay, decel_count, slow-down step,
                                  // accel_count_init, next_compare
    logic         i_cfg_we;
    logic [1:0]   i_cfg_index;
    logic [63:0]  i_cfg_data;

    logic [31:0] scale_reg;
    logic [63:0] fdsq_reg;
    logic [15:0] alpha_reg;
    logic        busy_flags [MOTORS];
    t_plan       plans_due [$];
    int          fail_count;
    int          idle_cycles;
    bit          out_stall_long;

    stepper_ramp_planner_core #(.MOTOR_COUNT(MOTORS)) dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic t_plan plan_move(logic op, logic [3:0] m, logic [31:0] raw,
                                        logic [15:0] ac, logic [15:0] dc, logic [15:0] sp,
                                        logic [15:0] cur);
        t_plan p;
        logic [63:0] mag, first, mind, dv, dvs, maxl, accl;
        p = '0;
        mag = raw[31] ? {32'd0, -raw} : {32'd0, raw};
        if (raw[31] && mag == 0) mag = 64'h8000_0000;
        first = 0;
        mind = 0;
        dv = 0;
        if (op) begin
            busy_flags[m] = 1'b0;
            p.status = srp_pkg::ST_DONE;
        end else if (busy_flags[m]) begin
            p.status = srp_pkg::ST_BUSY;
        end else if (mag == 0) begin
            p.status = srp_pkg::ST_ZERO_STEP;
        end else if (ac == 0 || dc == 0 || sp == 0) begin
            p.status = srp_pkg::ST_ZERO_PAR;
        end else begin
            p.status = srp_pkg::ST_STARTED;
            p.dir = ~raw[31];
            if (mag == 1) begin
                p.acinit = 1'b1;
                p.ramp = srp_pkg::RAMP_DECEL;
                first = 64'(srp_pkg::SINGLE_STEP_DELAY);
            end else begin
                mind = scale_reg / sp;
                first = int_sqrt(fdsq_reg / ac);
                dvs = (64'(alpha_reg) * ac) / 10;
                if (dvs == 0) dvs = 1;
                maxl = (64'(sp) * sp) / dvs;
                if (maxl == 0) maxl = 1;
                accl = (mag * dc) / (64'(ac) + dc);
                if (accl == 0) accl = 1;
                dv = (accl <= maxl) ? mag - accl : (maxl * ac) / dc;
                if (dv == 0) dv = 1;
                p.dstart = 31'(mag - dv);
                if (first <= mind) begin
                    first = mind;
                    p.ramp = srp_pkg::RAMP_RUN;
                end else begin
                    p.ramp = srp_pkg::RAMP_ACCEL;
                end
            end
            p.first = first[31:0];
            p.mind = mind[31:0];
            p.dcount = 32'(-dv);
            p.nextc = cur + first[16:1];
            busy_flags[m] = 1'b1;
        end
        return p;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_beat(logic op, logic [3:0] m, logic [31:0] st, logic [15:0] ac,
                             logic [15:0] dc, logic [15:0] sp, logic [15:0] cur);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {4'd0, cur, sp, dc, ac, st, m};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        plans_due.push_back(plan_move(op, m, st, ac, dc, sp, cur));
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (plans_due.size() != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            srp_pkg::CFG_SPEED_SCALE:    scale_reg = val[31:0];
            srp_pkg::CFG_FIRST_DELAY_SQ: fdsq_reg = val;
            default:                     alpha_reg = val[15:0];
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_regs(logic [31:0] sc, logic [63:0] sq, logic [15:0] al);
        write_reg(srp_pkg::CFG_SPEED_SCALE, sc);
        write_reg(srp_pkg::CFG_FIRST_DELAY_SQ, sq);
        write_reg(srp_pkg::CFG_ALPHA_X200, {48'd0, al});
    endtask

    task automatic free_all();
        for (int m = 0; m < MOTORS; m++)
            send_beat(1'b1, m[3:0], $urandom, 16'd0, 16'd0, 16'd0, 16'd0);
    endtask

    task automatic test_directed();
        set_regs(32'd2_000_000, 64'd40_000_000_000, 16'd63);
        send_beat(1'b0, 4'd0, 32'd0, 16'd100, 16'd100, 16'd100, 16'd0);
        send_beat(1'b0, 4'd0, 32'd5, 16'd0, 16'd100, 16'd100, 16'd0);
        send_beat(1'b0, 4'd0, 32'd5, 16'd100, 16'd0, 16'd100, 16'd0);
        send_beat(1'b0, 4'd0, 32'd5, 16'd100, 16'd100, 16'd0, 16'd0);
        send_beat(1'b0, 4'd1, 32'd1, 16'd0, 16'd100, 16'd100, 16'd5);
        send_beat(1'b0, 4'd1, 32'd1, 16'd1, 16'd1, 16'd1, 16'hFFFF);
        send_beat(1'b0, 4'd1, 32'd500, 16'd10, 16'd10, 16'd10, 16'd0);
        send_beat(1'b1, 4'd1, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_beat(1'b1, 4'd1, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_beat(1'b0, 4'd2, 32'hFFFF_FFFF, 16'd5, 16'd5, 16'd5, 16'd9);
        send_beat(1'b0, 4'd3, 32'h8000_0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_beat(1'b0, 4'd4, 32'h7FFF_FFFF, 16'd1, 16'hFFFF, 16'hFFFF, 16'hF000);
        send_beat(1'b0, 4'd5, 32'd2, 16'd1, 16'd1, 16'd1, 16'd0);
        send_beat(1'b0, 4'd6, 32'h8000_0001, 16'hFFFF, 16'd1, 16'd1, 16'd1);
        send_beat(1'b0, 4'd15, 32'd1000, 16'd3, 16'd7, 16'd3000, 16'd77);
        send_beat(1'b0, 4'd7, 32'd1000, 16'd3, 16'd7, 16'd2, 16'd77);
        drain();
        set_regs(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
        free_all();
        send_beat(1'b0, 4'd8, 32'd100_000, 16'd1, 16'd1, 16'd1, 16'd3);
        send_beat(1'b0, 4'd9, -32'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd3);
        drain();
        set_regs(32'd0, 64'd0, 16'd1);
        free_all();
        send_beat(1'b0, 4'd10, 32'd50, 16'd9, 16'd4, 16'd1, 16'd0);
        drain();
    endtask

    task automatic test_random(int n);
        int r;
        logic [31:0] st;
        logic [15:0] ac, dc, sp;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            case ($urandom_range(0, 3))
                0: st = $urandom;
                1: st = $urandom_range(0, 3) - 1;
                2: st = $urandom_range(0, 5000);
                default: st = -$urandom_range(0, 5000);
            endcase
            ac = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 300));
            dc = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 300));
            sp = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 3000));
            if (r < 3) ac = 0;
            else if (r < 6) sp = 0;
            else if (r < 9) dc = 0;
            send_beat($urandom_range(0, 99) < 40, 4'($urandom_range(0, 15)), st, ac, dc, sp,
                      16'($urandom));
        end
        drain();
    endtask

    task automatic test_settings();
        set_regs($urandom, {$urandom, $urandom}, 16'($urandom_range(1, 65535)));
        free_all();
        test_random(600);
        set_regs($urandom_range(0, 100000), 64'($urandom_range(0, 1 << 30)),
                 16'($urandom_range(1, 20)));
        free_all();
        test_random(650);
        set_regs($urandom, {$urandom_range(0, 1023), $urandom},
                 16'($urandom_range(1000, 65535)));
        free_all();
        test_random(600);
    endtask

    always @(negedge i_clk) begin
        out_stall_long <= ($urandom_range(0, 199) == 0) ? ~out_stall_long : out_stall_long;
        m_axis_tready <= out_stall_long ? ($urandom_range(0, 19) == 0)
                                        : ($urandom_range(0, 3) != 0);
    end

    always @(posedge i_clk) begin
        t_plan got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[149:0];
            if (plans_due.size() == 0) begin
                $display("%0t: unexpected beat %h", $time, got);
                fail_count++;
            end else begin
                want = plans_due.pop_front();
                if (got.status !== want.status)
                    $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                if (got.dir !== want.dir)
                    $display("%0t: direction exp %0d got %0d", $time, want.dir, got.dir);
                if (got.ramp !== want.ramp)
                    $display("%0t: ramp exp %0d got %0d", $time, want.ramp, got.ramp);
                if (got.first !== want.first)
                    $display("%0t: first exp %0d got %0d", $time, want.first, got.first);
                if (got.mind !== want.mind)
                    $display("%0t: min exp %0d got %0d", $time, want.mind, got.mind);
                if (got.dcount !== want.dcount)
                    $display("%0t: dcount exp %h got %h", $time, want.dcount, got.dcount);
                if (got.dstart !== want.dstart)
                    $display("%0t: dstart exp %0d got %0d", $time, want.dstart, got.dstart);
                if (got.acinit !== want.acinit)
                    $display("%0t: acinit exp %0d got %0d", $time, want.acinit, got.acinit);
                if (got.nextc !== want.nextc)
                    $display("%0t: nextc exp %0d got %0d", $time, want.nextc, got.nextc);
                if (got !== want) fail_count++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        out_stall_long = 1'b0;
        fail_count = 0;
        idle_cycles = 0;
        scale_reg = 0;
        fdsq_reg = 0;
        alpha_reg = 1;
        for (int m = 0; m < MOTORS; m++) busy_flags[m] = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_settings();
        if (fail_count == 0 && plans_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/srp_pkg.sv
rtl/srp_front.sv
rtl/srp_divsqrt.sv
rtl/srp_back.sv
rtl/srp_queue.sv
rtl/stepper_ramp_planner_core.sv
tb/sv/stepper_ramp_planner_core_tb.sv
